FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hw/rtl/nau_pkg.sv
// Types, constants and lookup tables of the activation unit
package nau_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int INDEX_W    = 6;
  localparam int CNT_W      = 7;
  localparam int EXP_W      = 32;
  localparam int SUM_W      = 40;
  localparam int DIV_NUM_W  = 56;
  localparam int DIV_DEN_W  = 40;
  localparam int DIV_Q_W    = 25;
  localparam int SLOPE_W    = 12;
  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int MUL_W      = 26;

  localparam logic [FUNC_W-1:0] FUNC_RELU    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LEAKY   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SIGMOID = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TANH    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SILU    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SOFTMAX = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_FUNC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = 2'd2;

  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 12'd41;

  typedef enum logic [2:0] {
    OP_RELU, OP_LEAKY, OP_SIGMOID, OP_TANH, OP_SILU, OP_SOFTMAX
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXPA, ST_EXPB, ST_STORE, ST_SQ, ST_SIGDIV, ST_TDIV,
    ST_EMRD, ST_EMDIV, ST_WAIT, ST_POST1, ST_POST2, ST_OUT
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic               deriv;
    logic [SLOPE_W-1:0] slope;
  } cfg_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] x;
    logic                last;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [17:0] frac_tab(input logic [4:0] j);
    logic [17:0] v;
    case (j)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd69763;
      5'd2:  v = 18'd74262;
      5'd3:  v = 18'd79052;
      5'd4:  v = 18'd84150;
      5'd5:  v = 18'd89577;
      5'd6:  v = 18'd95354;
      5'd7:  v = 18'd101504;
      5'd8:  v = 18'd108051;
      5'd9:  v = 18'd115019;
      5'd10: v = 18'd122437;
      5'd11: v = 18'd130334;
      5'd12: v = 18'd138740;
      5'd13: v = 18'd147688;
      5'd14: v = 18'd157213;
      5'd15: v = 18'd167352;
      default: v = 18'd178145;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] int_tab(input logic [3:0] i);
    logic [30:0] v;
    case (i)
      4'd0:  v = 31'd352;
      4'd1:  v = 31'd956;
      4'd2:  v = 31'd2599;
      4'd3:  v = 31'd7065;
      4'd4:  v = 31'd19205;
      4'd5:  v = 31'd52206;
      4'd6:  v = 31'd141909;
      4'd7:  v = 31'd385750;
      4'd8:  v = 31'd1048576;
      4'd9:  v = 31'd2850325;
      4'd10: v = 31'd7747987;
      4'd11: v = 31'd21061212;
      4'd12: v = 31'd57250310;
      4'd13: v = 31'd155622477;
      4'd14: v = 31'd423025751;
      default: v = 31'd1149903210;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/neural_activation_unit.sv
// Activation unit top level: configuration registers, front queue, divider, back end
// Applies relu, leaky relu, sigmoid, tanh, silu or softmax (or a derivative)
// to signed Q4.12 elements arriving on the s_ stream; results leave on m_.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 function, 1 derivative, 2 leaky slope); write only while idle. A
// function write restarts the softmax vector.
// Elementwise modes give one transfer per element with tlast high. Softmax
// stores up to VECTOR_DEPTH elements and, on the element with tlast, sends
// one transfer per stored element, the last with tlast high.
// Relu and leaky relu bypass the divider; sigmoid, silu, tanh and softmax
// results each take one division, and tanh adds a squaring step. A softmax
// element holds the back end while its exponential is computed and stored.
// The 56-step restoring divider sets the long paths.
// A two-entry queue takes new elements while the back end works, and the
// output register holds a result while the receiver stalls; the back end
// then waits. Reset clears the queue, the vector state and the
// configuration (function relu, no derivative, slope 41).
`include "assert_macros.svh"
module neural_activation_unit #(
  parameter int VECTOR_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] activation_value, [21:16] element_index
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  nau_pkg::cfg_t     cfg;
  logic              cfg_clear;
  logic              q_valid;
  logic              q_ready;
  nau_pkg::item_t    q_item;
  nau_pkg::div_req_t div_req;
  nau_pkg::div_rsp_t div_rsp;
  logic [15:0]       m_value;
  logic [5:0]        m_index;

  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid && (cfg_index == nau_pkg::CFG_FUNC);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.func  <= nau_pkg::FUNC_RELU;
      cfg.deriv <= 1'b0;
      cfg.slope <= nau_pkg::SLOPE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        nau_pkg::CFG_FUNC:  cfg.func  <= cfg_data[nau_pkg::FUNC_W-1:0];
        nau_pkg::CFG_DERIV: cfg.deriv <= cfg_data[0];
        nau_pkg::CFG_SLOPE: cfg.slope <= cfg_data;
        default: ;
      endcase
    end
  end

  nau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  nau_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  nau_back #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_value   (m_value),
    .m_index   (m_index),
    .m_tlast   (m_tlast)
  );

  assign m_tdata = {2'b00, m_index, m_value};

  `ASSERT_IMP(a_div_start_idle, clk, rst, div_req.start, !div_rsp.busy, "divider started while busy")
  `ASSERT_NXT(a_div_done_idle, clk, rst, div_rsp.done, !div_rsp.busy, "divider busy after done")
  `ASSERT_IMP(a_open_run_softmax, clk, rst, m_tvalid && !m_tlast, cfg.func == nau_pkg::FUNC_SOFTMAX, "open run outside softmax")

endmodule

FILE: hw/rtl/nau_front.sv
// Input side: accept, classify and queue elements
module nau_front (
  input  logic                           clk,
  input  logic                           rst,
  input  nau_pkg::cfg_t                  cfg,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [nau_pkg::SAMPLE_W-1:0]   s_tdata,
  input  logic                           s_tlast,
  output logic                           q_valid,
  input  logic                           q_ready,
  output nau_pkg::item_t                 q_item
);

  nau_pkg::item_t entry [2];
  nau_pkg::item_t item_in;
  nau_pkg::op_t   op_in;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  always_comb begin
    case (cfg.func)
      nau_pkg::FUNC_LEAKY:   op_in = nau_pkg::OP_LEAKY;
      nau_pkg::FUNC_SIGMOID: op_in = nau_pkg::OP_SIGMOID;
      nau_pkg::FUNC_TANH:    op_in = nau_pkg::OP_TANH;
      nau_pkg::FUNC_SILU:    op_in = nau_pkg::OP_SILU;
      nau_pkg::FUNC_SOFTMAX: op_in = nau_pkg::OP_SOFTMAX;
      default:               op_in = nau_pkg::OP_RELU;
    endcase
  end

  assign item_in  = '{op: op_in, x: s_tdata, last: s_tlast};
  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= item_in;
  end

endmodule

FILE: hw/rtl/nau_div.sv
// Radix-2 restoring divider, one quotient bit per cycle
module nau_div (
  input  logic              clk,
  input  logic              rst,
  input  nau_pkg::div_req_t req,
  output nau_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(nau_pkg::DIV_NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(nau_pkg::DIV_NUM_W - 1);

  logic [nau_pkg::DIV_DEN_W-1:0] rem;
  logic [nau_pkg::DIV_DEN_W-1:0] den;
  logic [nau_pkg::DIV_NUM_W-1:0] qn;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic                          done;
  logic [nau_pkg::DIV_DEN_W:0]   trial;
  logic                          ge;

  assign trial = {rem, qn[nau_pkg::DIV_NUM_W-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // hold the divisor for the whole run
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      den <= req.den;
      qn  <= req.num;
    end else if (busy) begin
      rem <= ge ? nau_pkg::DIV_DEN_W'(trial - {1'b0, den})
                : trial[nau_pkg::DIV_DEN_W-1:0];
      qn  <= {qn[nau_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp = '{busy: busy, done: done, quot: qn[nau_pkg::DIV_Q_W-1:0]};

endmodule

FILE: hw/rtl/nau_back.sv
// Execution side: exponential, function sequencer, softmax store and result register
module nau_back #(
  parameter int VECTOR_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  nau_pkg::cfg_t                  cfg,
  input  logic                           cfg_clear,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  nau_pkg::item_t                 q_item,
  output nau_pkg::div_req_t              div_req,
  input  nau_pkg::div_rsp_t              div_rsp,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [nau_pkg::SAMPLE_W-1:0]   m_value,
  output logic [nau_pkg::INDEX_W-1:0]    m_index,
  output logic                           m_tlast
);

  localparam int ADDR_W = $clog2(VECTOR_DEPTH);
  localparam logic [nau_pkg::CNT_W-1:0] DEPTH_C = nau_pkg::CNT_W'(VECTOR_DEPTH);
  localparam int FIN_W = 54;

  nau_pkg::state_t state, state_next;
  nau_pkg::op_t    op;

  logic signed [15:0]             x;
  logic                           last;
  logic [nau_pkg::INDEX_W-1:0]    idx;
  logic [15:0]                    exp_arg;
  logic [3:0]                     ei;
  logic [3:0]                     ej;
  logic [21:0]                    mul1;
  logic [48:0]                    mul2;
  logic [41:0]                    sq;
  logic signed [51:0]             mulp;
  logic [nau_pkg::CNT_W-1:0]      count;
  logic [nau_pkg::SUM_W-1:0]      sum;
  logic [nau_pkg::CNT_W-1:0]      k;
  logic [nau_pkg::EXP_W-1:0]      mem [VECTOR_DEPTH];
  logic [nau_pkg::EXP_W-1:0]      mem_q;

  logic signed [15:0]             xi;
  logic signed [16:0]             negx;
  logic [15:0]                    neg_clamp;
  logic [15:0]                    tanh_abs;
  logic [15:0]                    arg_in;
  logic [15:0]                    u;
  logic [13:0]                    diff;
  logic [17:0]                    fr;
  logic [nau_pkg::EXP_W-1:0]      e;
  logic [32:0]                    d_sig;
  logic [21:0]                    e_t;
  logic [21:0]                    den_t;
  logic [nau_pkg::DIV_Q_W-1:0]    q;
  logic signed [nau_pkg::MUL_W-1:0] qa;
  logic signed [nau_pkg::MUL_W-1:0] mul_a;
  logic signed [nau_pkg::MUL_W-1:0] mul_b;
  logic signed [FIN_W-1:0]        mulp_x;
  logic signed [FIN_W-1:0]        r12;
  logic signed [FIN_W-1:0]        r24;
  logic signed [FIN_W-1:0]        r36;
  logic signed [FIN_W-1:0]        qx;
  logic signed [FIN_W-1:0]        xx;
  logic signed [FIN_W-1:0]        fin;
  logic [15:0]                    fin_sat;
  logic                           can_load;
  logic                           load;
  logic                           emit_final;
  logic                           elementwise;

  assign xi   = $signed(q_item.x);
  assign negx = -{xi[15], xi};
  assign neg_clamp = (negx > 17'sd32767) ? 16'h7fff : negx[15:0];
  assign tanh_abs  = xi[15] ? neg_clamp : q_item.x;

  always_comb begin
    case (q_item.op)
      nau_pkg::OP_SOFTMAX: arg_in = q_item.x;
      nau_pkg::OP_TANH:    arg_in = 16'(-tanh_abs);
      default:             arg_in = neg_clamp;
    endcase
  end

  assign u    = {~exp_arg[15], exp_arg[14:0]};
  assign diff = 14'(nau_pkg::frac_tab({1'b0, u[11:8]} + 5'd1)
                    - nau_pkg::frac_tab({1'b0, u[11:8]}));
  assign fr   = nau_pkg::frac_tab({1'b0, ej}) + 18'(mul1 >> 8);
  assign e    = mul2[47:16];

  assign d_sig = 33'd1048576 + {1'b0, e};
  assign e_t   = 22'((sq + 42'd524288) >> 20);
  assign den_t = 22'd1048576 + e_t;

  always_comb begin
    div_req = '{start: 1'b0, num: '0, den: '0};
    case (state)
      nau_pkg::ST_SIGDIV: begin
        div_req.start = 1'b1;
        div_req.num = (nau_pkg::DIV_NUM_W'(1) << 32) + nau_pkg::DIV_NUM_W'(d_sig >> 1);
        div_req.den = nau_pkg::DIV_DEN_W'(d_sig);
      end
      nau_pkg::ST_TDIV: begin
        div_req.start = 1'b1;
        div_req.num = (nau_pkg::DIV_NUM_W'(22'd1048576 - e_t) << 12)
                      + nau_pkg::DIV_NUM_W'(den_t >> 1);
        div_req.den = nau_pkg::DIV_DEN_W'(den_t);
      end
      nau_pkg::ST_EMDIV: begin
        div_req.start = 1'b1;
        div_req.num = {mem_q, 24'd0};
        div_req.den = sum;
      end
      default: ;
    endcase
  end

  assign q  = div_rsp.quot;
  assign qa = $signed({1'b0, q});

  always_comb begin
    mul_a = nau_pkg::MUL_W'(x);
    mul_b = qa;
    if (state == nau_pkg::ST_POST2) begin
      mul_a = nau_pkg::MUL_W'(x);
      mul_b = mulp[nau_pkg::MUL_W-1:0];
    end else begin
      case (op)
        nau_pkg::OP_LEAKY: begin
          mul_a = nau_pkg::MUL_W'(x);
          mul_b = $signed({14'd0, cfg.slope});
        end
        nau_pkg::OP_SIGMOID: begin
          mul_a = qa;
          mul_b = 26'sd4096 - qa;
        end
        nau_pkg::OP_TANH: begin
          mul_a = qa;
          mul_b = qa;
        end
        nau_pkg::OP_SILU: begin
          mul_a = cfg.deriv ? qa : nau_pkg::MUL_W'(x);
          mul_b = cfg.deriv ? (26'sd4096 - qa) : qa;
        end
        nau_pkg::OP_SOFTMAX: begin
          mul_a = qa;
          mul_b = 26'sd16777216 - qa;
        end
        default: ;
      endcase
    end
  end

  assign mulp_x = FIN_W'(mulp);
  assign r12 = (mulp_x + 54'sd2048) >>> 12;
  assign r24 = (mulp_x + 54'sd8388608) >>> 24;
  assign r36 = (mulp_x + 54'sd34359738368) >>> 36;
  assign qx  = $signed({29'd0, q});
  assign xx  = FIN_W'(x);

  always_comb begin
    case (op)
      nau_pkg::OP_LEAKY:
        fin = (x > 16'sd0) ? (cfg.deriv ? 54'sd4096 : xx)
                           : (cfg.deriv ? $signed({42'd0, cfg.slope}) : r12);
      nau_pkg::OP_SIGMOID: fin = cfg.deriv ? r12 : qx;
      nau_pkg::OP_TANH:    fin = cfg.deriv ? (54'sd4096 - r12) : (x[15] ? -qx : qx);
      nau_pkg::OP_SILU:    fin = cfg.deriv ? (r24 + qx) : r12;
      nau_pkg::OP_SOFTMAX:
        fin = (sum == '0) ? 54'sd0 : (cfg.deriv ? r36 : ((qx + 54'sd2048) >>> 12));
      default:
        fin = (x > 16'sd0) ? (cfg.deriv ? 54'sd4096 : xx) : 54'sd0;
    endcase
    if (fin > 54'sd32767) fin_sat = 16'h7fff;
    else if (fin < -54'sd32768) fin_sat = 16'h8000;
    else fin_sat = fin[15:0];
  end

  assign can_load   = !m_tvalid || m_tready;
  assign load       = (state == nau_pkg::ST_OUT) && can_load;
  assign emit_final = ((k + 1'b1) == count);
  assign elementwise = (q_item.op != nau_pkg::OP_SOFTMAX);
  assign q_ready    = (state == nau_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= nau_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      nau_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            nau_pkg::OP_RELU:  state_next = nau_pkg::ST_OUT;
            nau_pkg::OP_LEAKY: state_next = nau_pkg::ST_POST1;
            nau_pkg::OP_SOFTMAX: begin
              if (count < DEPTH_C) state_next = nau_pkg::ST_EXPA;
              else if (q_item.last) state_next = nau_pkg::ST_EMRD;
              else state_next = nau_pkg::ST_IDLE;
            end
            default: state_next = nau_pkg::ST_EXPA;
          endcase
        end
      end
      nau_pkg::ST_EXPA: state_next = nau_pkg::ST_EXPB;
      nau_pkg::ST_EXPB: begin
        case (op)
          nau_pkg::OP_SOFTMAX: state_next = nau_pkg::ST_STORE;
          nau_pkg::OP_TANH:    state_next = nau_pkg::ST_SQ;
          default:             state_next = nau_pkg::ST_SIGDIV;
        endcase
      end
      nau_pkg::ST_STORE: state_next = last ? nau_pkg::ST_EMRD : nau_pkg::ST_IDLE;
      nau_pkg::ST_SQ:    state_next = nau_pkg::ST_TDIV;
      nau_pkg::ST_SIGDIV, nau_pkg::ST_TDIV, nau_pkg::ST_EMDIV:
        state_next = nau_pkg::ST_WAIT;
      nau_pkg::ST_EMRD:  state_next = nau_pkg::ST_EMDIV;
      nau_pkg::ST_WAIT:  if (div_rsp.done) state_next = nau_pkg::ST_POST1;
      nau_pkg::ST_POST1:
        state_next = (op == nau_pkg::OP_SILU && cfg.deriv) ? nau_pkg::ST_POST2
                                                           : nau_pkg::ST_OUT;
      nau_pkg::ST_POST2: state_next = nau_pkg::ST_OUT;
      nau_pkg::ST_OUT: begin
        if (can_load) begin
          if (op == nau_pkg::OP_SOFTMAX && !emit_final) state_next = nau_pkg::ST_EMRD;
          else state_next = nau_pkg::ST_IDLE;
        end
      end
      default: state_next = nau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else if (cfg_clear) begin
      count <= '0;
      sum   <= '0;
    end else begin
      case (state)
        nau_pkg::ST_IDLE:
          if (q_valid && elementwise)
            count <= q_item.last ? '0 : {1'b0, count[nau_pkg::INDEX_W-1:0] + 1'b1};
        nau_pkg::ST_STORE: begin
          sum   <= sum + nau_pkg::SUM_W'(e);
          count <= count + 1'b1;
        end
        nau_pkg::ST_OUT:
          if (can_load && op == nau_pkg::OP_SOFTMAX && emit_final) begin
            count <= '0;
            sum   <= '0;
          end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      nau_pkg::ST_IDLE:
        if (q_valid) begin
          op      <= q_item.op;
          x       <= xi;
          last    <= q_item.last;
          exp_arg <= arg_in;
          idx     <= count[nau_pkg::INDEX_W-1:0];
          k       <= '0;
        end
      nau_pkg::ST_EXPA: begin
        mul1 <= 22'(diff) * 22'(u[7:0]);
        ei   <= u[15:12];
        ej   <= u[11:8];
      end
      nau_pkg::ST_EXPB: mul2 <= 49'(nau_pkg::int_tab(ei)) * 49'(fr);
      nau_pkg::ST_SQ:   sq <= 42'(e[20:0]) * 42'(e[20:0]);
      nau_pkg::ST_POST1, nau_pkg::ST_POST2: mulp <= mul_a * mul_b;
      nau_pkg::ST_OUT:  if (can_load && op == nau_pkg::OP_SOFTMAX) k <= k + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == nau_pkg::ST_STORE) mem[count[ADDR_W-1:0]] <= e;
    mem_q <= mem[k[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_value <= fin_sat;
      m_index <= (op == nau_pkg::OP_SOFTMAX) ? k[nau_pkg::INDEX_W-1:0] : idx;
      m_tlast <= (op == nau_pkg::OP_SOFTMAX) ? emit_final : 1'b1;
    end
  end

endmodule
